// File: design/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Both macros sample on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in every cycle.
`define FFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that, once seen, must be followed in the next cycle by another.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ffsa_pkg.sv
`default_nettype none

package ffsa_pkg;

  localparam int SLOT_MAX   = 64;
  localparam int MASK_W     = 32;
  localparam int CAND_MAX   = 6;
  localparam int WIDTH_W    = 7;
  localparam int START_W    = 6;
  localparam int COUNT_W    = 3;
  localparam int PATH_W     = 3;
  localparam int SCAN_STEPS = WIDTH_W;

  localparam logic [WIDTH_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_BLOCKED   = 2'd1,
    ST_RELEASED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_ALLOC   = 2'd0,
    JOB_RELEASE = 2'd1,
    JOB_BLOCKED = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic                opcode;
    logic [WIDTH_W-1:0]  width;
    logic [START_W-1:0]  start_slot;
    logic [COUNT_W-1:0]  path_count;
    logic [MASK_W-1:0]   path_mask_0;
    logic [MASK_W-1:0]   path_mask_1;
    logic [MASK_W-1:0]   path_mask_2;
    logic [MASK_W-1:0]   path_mask_3;
    logic [MASK_W-1:0]   path_mask_4;
    logic [MASK_W-1:0]   path_mask_5;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [PATH_W-1:0]   chosen_path;
    logic [START_W-1:0]  first_slot;
  } res_t;

  // A classified command as it waits between the front and the back.
  typedef struct packed {
    job_kind_e                       kind;
    logic [WIDTH_W-1:0]              width;
    logic [SLOT_MAX-1:0]             range_mask;
    logic [SLOT_MAX-1:0]             rel_bits;
    logic [CAND_MAX-1:0][MASK_W-1:0] masks;
  } job_t;

  function automatic logic [SLOT_MAX-1:0] low_ones(input logic [7:0] n);
    logic [SLOT_MAX-1:0] r;
    for (int i = 0; i < SLOT_MAX; i++) begin
      r[i] = (8'(i) < n);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/first_fit_spectrum_allocator.sv
// Channel    Direction  Signals                               Transaction when
// command    in         start, busy, in_i                     start && !busy
// config     in         cfg_valid_i, cfg_ready_o, cfg_data_i  cfg_valid_i && cfg_ready_o
// result     out        done_o, result_o                      done_o (one cycle, no stall)
//
// Accepted commands wait in a two-entry queue; busy is high only while it is full.
// A blocked command is answered straight from the back's idle state; a release
// passes through the clear state first. An allocate tries each candidate in turn:
// one with links passes through gather (an OR of its link rows), 7 run-doubling
// steps in scan and a pick; an empty one is skipped in gather; a grant then marks.
// Reset clears the occupancy table at once; no sweep follows.
`default_nettype none

module first_fit_spectrum_allocator import ffsa_pkg::*; #(
  parameter int EDGES      = 32,
  parameter int SLOTS      = 64,
  parameter int CANDIDATES = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire req_t               in_i,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [WIDTH_W-1:0] cfg_data_i,
  output      logic               done_o,
  output      res_t               result_o
);

  localparam int LINKS = (EDGES < MASK_W) ? EDGES : MASK_W;

  logic push;
  logic full;
  logic pop;
  logic job_valid;
  job_t front_job;
  job_t queue_job;

  assign busy        = full;
  assign cfg_ready_o = 1'b1;

  ffsa_front #(
    .SLOTS      (SLOTS),
    .CANDIDATES (CANDIDATES),
    .LINKS      (LINKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (in_i),
    .full_i      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .job_o       (front_job)
  );

  ffsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (job_valid),
    .job_o   (queue_job)
  );

  ffsa_back #(
    .SLOTS      (SLOTS),
    .CANDIDATES (CANDIDATES),
    .LINKS      (LINKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (queue_job),
    .pop_o       (pop),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// File: design/ffsa_front.sv
`default_nettype none

module ffsa_front import ffsa_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int CANDIDATES = 6,
  parameter int LINKS      = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire req_t               req_i,
  input  wire logic               full_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [WIDTH_W-1:0] cfg_data_i,
  output      logic               push_o,
  output      job_t               job_o
);

  logic [WIDTH_W-1:0]              cfg_q;
  logic [WIDTH_W-1:0]              rng;
  logic [SLOT_MAX-1:0]             rmask;
  logic [7:0]                      sum_w;
  logic [7:0]                      end_w;
  logic [COUNT_W-1:0]              count;
  logic [SLOT_MAX-1:0]             lnk_full;
  logic [MASK_W-1:0]               lnk;
  logic [CAND_MAX-1:0][MASK_W-1:0] pm;
  logic                            blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign push_o = start_i && !full_i;

  always_comb begin
    rng      = (cfg_q > WIDTH_W'(SLOTS)) ? WIDTH_W'(SLOTS) : cfg_q;
    rmask    = low_ones({1'b0, rng});
    lnk_full = low_ones(8'(LINKS));
    lnk      = lnk_full[MASK_W-1:0];
    sum_w    = {2'b00, req_i.start_slot} + {1'b0, req_i.width};
    end_w    = (sum_w > {1'b0, rng}) ? {1'b0, rng} : sum_w;
    count = (req_i.path_count > COUNT_W'(CANDIDATES)) ? COUNT_W'(CANDIDATES)
                                                      : req_i.path_count;
    pm[0] = req_i.path_mask_0;
    pm[1] = req_i.path_mask_1;
    pm[2] = req_i.path_mask_2;
    pm[3] = req_i.path_mask_3;
    pm[4] = req_i.path_mask_4;
    pm[5] = req_i.path_mask_5;
    blocked = (req_i.width == '0) || (req_i.width > rng) || (count == '0);

    job_o            = '0;
    job_o.width      = req_i.width;
    job_o.range_mask = rmask;
    if (opcode_e'(req_i.opcode) == OP_RELEASE) begin
      job_o.kind     = JOB_RELEASE;
      job_o.masks[0] = pm[0] & lnk;
      if ({1'b0, req_i.start_slot} < rng && req_i.width != '0) begin
        job_o.rel_bits = low_ones(end_w) & ~low_ones({2'b00, req_i.start_slot}) & rmask;
      end
    end else begin
      job_o.kind = blocked ? JOB_BLOCKED : JOB_ALLOC;
      // Candidates past the count become empty masks, which the back skips.
      for (int k = 0; k < CAND_MAX; k++) begin
        job_o.masks[k] = (COUNT_W'(k) < count) ? (pm[k] & lnk) : '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/ffsa_queue.sv
`default_nettype none
`include "assert_macros.svh"

module ffsa_queue import ffsa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output      logic full_o,
  output      logic valid_o,
  output      job_t job_o
);

  localparam int DEPTH = 2;

  job_t       ent_q [DEPTH];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `FFSA_ASSERT(a_no_overflow, !(push_i && full_o && !pop_i), "push into a full queue")
  `FFSA_ASSERT(a_no_underflow, !(pop_i && !valid_o), "pop from an empty queue")

endmodule

`default_nettype wire

// File: design/ffsa_back.sv
`default_nettype none
`include "assert_macros.svh"

module ffsa_back import ffsa_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int CANDIDATES = 6,
  parameter int LINKS      = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output      logic pop_o,
  output      logic done_o,
  output      res_t result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_SCAN,
    S_PICK,
    S_MARK,
    S_CLEAR
  } state_e;

  state_e             state_q;
  job_t               job_q;
  logic [PATH_W-1:0]  cand_q;
  logic [SLOTS-1:0]   free_q;
  logic [SLOTS-1:0]   fit_q;
  logic [WIDTH_W-1:0] len_q;
  logic [2:0]         step_q;
  logic [START_W-1:0] slot_q;
  logic               done_q;
  res_t               res_q;
  logic [SLOTS-1:0]   table_q [LINKS];

  logic [LINKS-1:0]    cur_mask;
  logic [SLOTS-1:0]    occ;
  logic [SLOTS-1:0]    rmask;
  logic [SLOT_MAX-1:0] wmask_full;
  logic [SLOTS-1:0]    wmask;
  logic [SLOTS-1:0]    mark_bits;
  logic [WIDTH_W-1:0]  pow;
  logic                use_step;
  logic [SLOTS-1:0]    fit_nx;
  logic [SLOTS-1:0]    free_nx;
  logic [WIDTH_W-1:0]  len_nx;
  logic                found;
  logic [START_W-1:0]  idx;
  logic                last_cand;

  assign pop_o    = (state_q == S_IDLE) && job_valid_i;
  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    cur_mask   = job_q.masks[cand_q][LINKS-1:0];
    rmask      = job_q.range_mask[SLOTS-1:0];
    wmask_full = low_ones({1'b0, job_q.width});
    wmask      = wmask_full[SLOTS-1:0];
    mark_bits  = wmask << slot_q;
    last_cand  = (cand_q == PATH_W'(CANDIDATES - 1));
    occ        = '0;
    for (int e = 0; e < LINKS; e++) begin
      if (cur_mask[e]) begin
        occ = occ | table_q[e];
      end
    end
    // Run doubling: free_q marks starts of free runs of length 2**step_q,
    // fit_q marks starts of free runs of length len_q.
    pow      = WIDTH_W'(1) << step_q;
    use_step = job_q.width[step_q];
    fit_nx   = use_step ? (fit_q & (free_q >> len_q)) : fit_q;
    len_nx   = use_step ? (len_q + pow) : len_q;
    free_nx  = free_q & (free_q >> pow);
    found    = 1'b0;
    idx      = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (fit_q[i]) begin
        found = 1'b1;
        idx   = START_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cand_q  <= '0;
      step_q  <= '0;
      job_q   <= '0;
      free_q  <= '0;
      fit_q   <= '0;
      len_q   <= '0;
      slot_q  <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            cand_q <= '0;
            unique case (job_i.kind)
              JOB_ALLOC: begin
                state_q <= S_GATHER;
              end
              JOB_RELEASE: begin
                state_q <= S_CLEAR;
              end
              default: begin
                done_q            <= 1'b1;
                res_q.status      <= ST_BLOCKED;
                res_q.chosen_path <= '0;
                res_q.first_slot  <= '0;
              end
            endcase
          end
        end
        S_GATHER: begin
          if (cur_mask == '0) begin
            if (last_cand) begin
              done_q            <= 1'b1;
              res_q.status      <= ST_BLOCKED;
              res_q.chosen_path <= '0;
              res_q.first_slot  <= '0;
              state_q           <= S_IDLE;
            end else begin
              cand_q <= cand_q + PATH_W'(1);
            end
          end else begin
            free_q  <= ~occ & rmask;
            fit_q   <= '1;
            len_q   <= '0;
            step_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          fit_q  <= fit_nx;
          free_q <= free_nx;
          len_q  <= len_nx;
          step_q <= step_q + 3'd1;
          if (step_q == 3'(SCAN_STEPS - 1)) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (found) begin
            slot_q  <= idx;
            state_q <= S_MARK;
          end else if (last_cand) begin
            done_q            <= 1'b1;
            res_q.status      <= ST_BLOCKED;
            res_q.chosen_path <= '0;
            res_q.first_slot  <= '0;
            state_q           <= S_IDLE;
          end else begin
            cand_q  <= cand_q + PATH_W'(1);
            state_q <= S_GATHER;
          end
        end
        S_MARK: begin
          done_q            <= 1'b1;
          res_q.status      <= ST_ALLOCATED;
          res_q.chosen_path <= cand_q;
          res_q.first_slot  <= slot_q;
          state_q           <= S_IDLE;
        end
        S_CLEAR: begin
          done_q            <= 1'b1;
          res_q.status      <= ST_RELEASED;
          res_q.chosen_path <= '0;
          res_q.first_slot  <= '0;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy rows; a release always works on candidate slot zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < LINKS; e++) begin
        table_q[e] <= '0;
      end
    end else begin
      for (int e = 0; e < LINKS; e++) begin
        if (cur_mask[e] && state_q == S_MARK) begin
          table_q[e] <= table_q[e] | mark_bits;
        end else if (cur_mask[e] && state_q == S_CLEAR) begin
          table_q[e] <= table_q[e] & ~job_q.rel_bits[SLOTS-1:0];
        end
      end
    end
  end

  `FFSA_ASSERT(a_mark_in_range, !(state_q == S_MARK && |(mark_bits & ~rmask)), "grant out of range")
  `FFSA_ASSERT_NEXT(a_rel_done, state_q == S_CLEAR, done_q && res_q.status == ST_RELEASED, "no release result")

endmodule

`default_nettype wire
